[rtl/mpt_pkg.sv]
package mpt_pkg;

    // Width of the sounding-key and peak counters, fixed by the result fields
    localparam int TALLY_W = 12;

    // Event kinds carried on the input tuser
    typedef enum logic [1:0] {
        ACT_NOTE_ON  = 2'd0,
        ACT_NOTE_OFF = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

    // Decoded operation of the item held in the update stage
    typedef struct packed {
        logic press;
        logic release_key;
        logic clear;
    } t_op_ctl;

endpackage

[rtl/midi_polyphony_tracker_core.sv]
// MIDI polyphony tracker. Each input transfer carries one note event (kind on
// tuser: note on, note off, clear) and produces exactly one output transfer with
// the number of channel/note keys sounding and the peak of that number since the
// last clear, both taken after the event is applied. Per-key counts live in one
// synchronous RAM of CHANNELS*NOTES entries: an event reads its key on the cycle
// it is accepted and writes it back on leaving the update stage, with the write
// forwarded to a following event on the same key, so one event per cycle is
// sustained while the output side keeps up. The output register lets a new event
// in while a result waits. A note on with zero velocity is a release; events on
// an out-of-range channel or note, or of the unused kind, change nothing and
// report the current counts. After reset, and after every clear event, the RAM
// is swept one entry a cycle (2048 entries at the defaults), while tready is low;
// the clear event's own result (both counts zero) is delivered without waiting.
module midi_polyphony_tracker_core
    import mpt_pkg::*;
#(
    parameter int CHANNELS   = 16,
    parameter int NOTES      = 128,
    parameter int COUNT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // channel[3:0], note[10:4], velocity[17:11], zero
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // active_keys[11:0], max_polyphony[23:12]
);

    localparam int KEYS  = CHANNELS * NOTES;
    localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;

    // Input field unpacking
    logic [3:0] in_channel;
    logic [6:0] in_note;
    logic [6:0] in_velocity;
    t_action    in_action;

    assign in_channel  = s_axis_tdata[3:0];
    assign in_note     = s_axis_tdata[10:4];
    assign in_velocity = s_axis_tdata[17:11];
    assign in_action   = t_action'(s_axis_tuser);

    // Control state
    logic                  r_s1_vld;
    logic                  r_out_vld;
    logic                  r_clr_busy;
    logic [KEY_W-1:0]      r_clr_addr;
    logic [TALLY_W-1:0]    r_sounding;
    logic [TALLY_W-1:0]    r_peak;

    // Payload state
    t_op_ctl               r_s1_op;
    logic [KEY_W-1:0]      r_s1_addr;
    logic                  r_fwd;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic [23:0]           r_out_data;

    logic                  accept;
    logic                  s1_fire;
    logic                  in_range;
    logic [11:0]           idx_full;
    logic [KEY_W-1:0]      in_addr;
    t_op_ctl               in_op;

    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  upd_we;
    logic [COUNT_BITS-1:0] upd_count;
    logic [TALLY_W-1:0]    n_sounding;
    logic [TALLY_W-1:0]    n_peak;

    logic                  ram_we;
    logic [KEY_W-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  item_we;

    // Advance the update stage only when the output slot is free or being emptied
    assign s1_fire = r_s1_vld && (!r_out_vld || m_axis_tready);

    // Hold off input during a sweep, and behind a clear that is about to start one
    assign s_axis_tready = !r_clr_busy && !(r_s1_vld && r_s1_op.clear)
                           && (!r_s1_vld || s1_fire);
    assign accept = s_axis_tvalid && s_axis_tready;

    // Decode the event and form the key address
    assign in_range = ({1'b0, in_channel} < 5'(CHANNELS)) && ({1'b0, in_note} < 8'(NOTES));
    assign idx_full = 12'(in_channel) * 12'(NOTES) + 12'(in_note);
    assign in_addr  = KEY_W'(idx_full);

    always_comb begin
        in_op = '0;
        case (in_action)
            ACT_NOTE_ON: begin
                in_op.press       = in_range && (in_velocity != '0);
                in_op.release_key = in_range && (in_velocity == '0);
            end
            ACT_NOTE_OFF: begin
                in_op.release_key = in_range;
            end
            ACT_CLEAR: begin
                in_op.clear = 1'b1;
            end
            default: begin
                in_op = '0;
            end
        endcase
    end

    mpt_key_ram #(
        .DEPTH  (KEYS),
        .ADDR_W (KEY_W),
        .DATA_W (COUNT_BITS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata)
    );

    // Take the forwarded count where the previous event wrote this key
    assign cur_count = r_fwd ? r_fwd_data : ram_rdata;

    mpt_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .i_op       (r_s1_op),
        .i_count    (cur_count),
        .i_sounding (r_sounding),
        .i_peak     (r_peak),
        .o_we       (upd_we),
        .o_count    (upd_count),
        .o_sounding (n_sounding),
        .o_peak     (n_peak)
    );

    // Share the write port between the update stage and the clearing sweep
    assign item_we   = s1_fire && upd_we;
    assign ram_we    = item_we || r_clr_busy;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clr_busy ? '0 : upd_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_sounding <= '0;
            r_peak     <= '0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end

            if (s1_fire) begin
                r_out_vld  <= 1'b1;
                r_sounding <= n_sounding;
                r_peak     <= n_peak;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            // Start the sweep when a clear leaves the update stage
            if (s1_fire && r_s1_op.clear) begin
                r_clr_busy <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clr_busy) begin
                if (r_clr_addr == KEY_W'(KEYS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + KEY_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= in_op;
            r_s1_addr  <= in_addr;
            r_fwd      <= item_we && (r_s1_addr == in_addr);
            r_fwd_data <= upd_count;
        end
        if (s1_fire) begin
            r_out_data <= {n_peak, n_sounding};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // A sweep in progress never overlaps an accepted event
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready)
        else $error("event accepted during clearing sweep");

    // The peak never falls below the number of sounding keys
    a_peak_covers_sounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_sounding)
        else $error("peak below sounding count");

    // A clear leaving the update stage zeroes the counts and starts the sweep
    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_op.clear) |=> (r_clr_busy && r_sounding == '0 && r_peak == '0))
        else $error("clear did not reset counts or start sweep");

    // The sweep owns the write port: no event write while it runs
    a_sweep_owns_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !item_we)
        else $error("event write during clearing sweep");

endmodule

[rtl/mpt_key_ram.sv]
module mpt_key_ram
    import mpt_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Read before write; hold the read data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mpt_update.sv]
module mpt_update
    import mpt_pkg::*;
#(
    parameter int COUNT_BITS = 8
) (
    input  t_op_ctl                i_op,
    input  logic [COUNT_BITS-1:0]  i_count,
    input  logic [TALLY_W-1:0]     i_sounding,
    input  logic [TALLY_W-1:0]     i_peak,
    output logic                   o_we,
    output logic [COUNT_BITS-1:0]  o_count,
    output logic [TALLY_W-1:0]     o_sounding,
    output logic [TALLY_W-1:0]     o_peak
);

    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

    logic                 silent;
    logic [TALLY_W-1:0]   sounding_up;

    assign silent      = (i_count == '0);
    assign sounding_up = i_sounding + TALLY_W'(1);

    always_comb begin
        o_we       = 1'b0;
        o_count    = i_count;
        o_sounding = i_sounding;
        o_peak     = i_peak;
        if (i_op.clear) begin
            o_sounding = '0;
            o_peak     = '0;
        end else if (i_op.press) begin
            o_we = 1'b1;
            if (silent) begin
                o_sounding = sounding_up;
                if (sounding_up > i_peak) begin
                    o_peak = sounding_up;
                end
            end
            if (i_count != CountMax) begin
                o_count = i_count + CountOne;
            end
        end else if (i_op.release_key) begin
            // drop a silent key's release
            if (!silent) begin
                o_we    = 1'b1;
                o_count = i_count - CountOne;
                if (i_count == CountOne && i_sounding != '0) begin
                    o_sounding = i_sounding - TALLY_W'(1);
                end
            end
        end
    end

endmodule

[test/midi_polyphony_tracker_core_tb.sv]
`timescale 1ns / 100ps

module midi_polyphony_tracker_core_tb;
    import mpt_pkg::*;

    localparam int KEYS       = 2048;
    localparam int IDLE_PCT   = 27;
    localparam int MAX_REPORT = 10;

    // Counts carried by one result transfer
    typedef struct packed {
        logic [TALLY_W-1:0] active;
        logic [TALLY_W-1:0] peak;
    } t_poly_counts;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // channel[3:0], note[10:4], velocity[17:11], zero
    logic [1:0]  s_axis_tuser;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // active_keys[11:0], max_polyphony[23:12]

    // Own copy of the key table and the two tallies
    logic [7:0]         key_tally [0:KEYS-1];
    logic [TALLY_W-1:0] keys_sounding;
    logic [TALLY_W-1:0] peak_sounding;

    t_poly_counts expected_counts [$];
    logic [10:0]  held_keys [$];    // one entry per press still outstanding
    int           mismatch_count;
    int           result_count;
    bit           no_idle;

    midi_polyphony_tracker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Start low so that reset is already driven at the first rising edge
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Apply one accepted event to the local table and queue the counts it reports
    task automatic apply_event(input t_action act, input logic [3:0] chan,
                               input logic [6:0] note, input logic [6:0] vel);
        logic [10:0] key;
        key = {chan, note};
        case (act)
            ACT_CLEAR: begin
                for (int k = 0; k < KEYS; k++) key_tally[k] = '0;
                keys_sounding = '0;
                peak_sounding = '0;
            end
            ACT_NOTE_ON, ACT_NOTE_OFF: begin
                if (act == ACT_NOTE_ON && vel != 7'd0) begin
                    if (key_tally[key] == 8'd0) begin
                        keys_sounding = keys_sounding + 1'b1;
                        if (keys_sounding > peak_sounding) peak_sounding = keys_sounding;
                    end
                    // saturate at the top of the per-key count
                    if (key_tally[key] != 8'hFF) key_tally[key] = key_tally[key] + 1'b1;
                end else if (key_tally[key] != 8'd0) begin
                    key_tally[key] = key_tally[key] - 1'b1;
                    if (key_tally[key] == 8'd0 && keys_sounding != '0)
                        keys_sounding = keys_sounding - 1'b1;
                end
            end
            default: ;  // unused kind: change nothing
        endcase
        expected_counts.push_back('{active: keys_sounding, peak: peak_sounding});
    endtask

    // Present one event from a falling edge and hold it until the transfer;
    // return at the falling edge after it
    task automatic send_event(input t_action act, input logic [3:0] chan,
                              input logic [6:0] note, input logic [6:0] vel);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'd0, vel, note, chan};
        s_axis_tuser  = act;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_event(act, chan, note, vel);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_key(input t_action act, input logic [10:0] key,
                            input logic [6:0] vel);
        send_event(act, key[3:0], key[10:4], vel);
    endtask

    // Hold until every queued result has come back
    task automatic wait_drained();
        while (expected_counts.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver side: stall at random unless in the steady stretch
    always @(negedge i_clk) begin
        m_axis_tready = no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_poly_counts want;
        t_poly_counts got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{active: m_axis_tdata[11:0], peak: m_axis_tdata[23:12]};
            result_count++;
            if (expected_counts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORT)
                    $display("%0t: result %0d with nothing expected: active %0d peak %0d",
                             $realtime, result_count, got.active, got.peak);
            end else begin
                want = expected_counts.pop_front();
                if (got.active !== want.active || got.peak !== want.peak) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT)
                        $display("%0t: result %0d: active exp %0d got %0d, peak exp %0d got %0d",
                                 $realtime, result_count, want.active, got.active,
                                 want.peak, got.peak);
                end
            end
        end
    end

    task automatic do_reset();
        for (int k = 0; k < KEYS; k++) key_tally[k] = '0;
        keys_sounding = '0;
        peak_sounding = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    endtask

    // Extremes of every field, every kind, release paths and the ignored cases
    task automatic test_directed();
        send_event(ACT_NOTE_ON,  4'd0,  7'd0,   7'd1);
        send_event(ACT_NOTE_ON,  4'd15, 7'd127, 7'd127);
        send_event(ACT_NOTE_ON,  4'd0,  7'd0,   7'd64);   // second instance, same key
        send_event(ACT_NOTE_OFF, 4'd0,  7'd0,   7'd127);
        send_event(ACT_NOTE_ON,  4'd0,  7'd0,   7'd0);    // zero velocity releases
        send_event(ACT_NOTE_OFF, 4'd0,  7'd0,   7'd0);    // silent key: ignore
        send_event(ACT_NONE,     4'd15, 7'd127, 7'd127);  // unused kind: ignore
        send_event(ACT_NONE,     4'd0,  7'd0,   7'd0);
        send_event(ACT_NOTE_OFF, 4'd15, 7'd127, 7'd0);    // peak must survive
        send_event(ACT_NOTE_ON,  4'd5,  7'd42,  7'd100);
        send_event(ACT_NOTE_ON,  4'd10, 7'h55,  7'h2A);
        send_event(ACT_NOTE_ON,  4'd5,  7'h2A,  7'h55);
        send_event(ACT_NOTE_ON,  4'd10, 7'h55,  7'h55);
        send_event(ACT_CLEAR,    4'd15, 7'd127, 7'd127);  // both counts to zero
        send_event(ACT_NOTE_OFF, 4'd5,  7'd42,  7'd1);    // table really empty
        send_event(ACT_NOTE_ON,  4'd5,  7'd42,  7'd127);
        send_event(ACT_NOTE_ON,  4'd15, 7'd0,   7'd1);
        send_event(ACT_NOTE_OFF, 4'd5,  7'd42,  7'd64);
        send_event(ACT_NOTE_ON,  4'd0,  7'd127, 7'd2);
        send_event(ACT_CLEAR,    4'd0,  7'd0,   7'd0);
    endtask

    // Drive one key into saturation, then step off it once
    task automatic test_key_saturation();
        logic [10:0] key;
        key = {7'd77, 4'd3};
        for (int n = 0; n < 258; n++) send_key(ACT_NOTE_ON, key, 7'($urandom_range(1, 127)));
        send_key(ACT_NOTE_OFF, key, 7'($urandom_range(0, 127)));
        send_event(ACT_CLEAR, 4'($urandom), 7'($urandom), 7'($urandom));
    endtask

    // Build a wide chord so the tallies climb well past a byte, then drop part of it
    task automatic test_wide_chord();
        for (int n = 0; n < 300; n++)
            send_key(ACT_NOTE_ON, 11'((n * 7) % KEYS), 7'($urandom_range(1, 127)));
        for (int n = 0; n < 60; n++)
            send_key(ACT_NOTE_OFF, 11'((n * 14) % KEYS), 7'($urandom_range(0, 127)));
        send_event(ACT_CLEAR, 4'($urandom), 7'($urandom), 7'($urandom));
    endtask

    // Mostly press/release pairs on sounding keys, with a hot set for repeats
    // and back-to-back hits, plus noise: silent releases, unused kind, clears
    task automatic random_events(input int count);
        int          pick;
        int          slot;
        logic [10:0] key;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 1) begin
                held_keys.delete();
                send_event(ACT_CLEAR, 4'($urandom), 7'($urandom), 7'($urandom));
            end else if (pick < 3) begin
                send_event(ACT_NONE, 4'($urandom), 7'($urandom), 7'($urandom));
            end else if (pick < 50) begin
                if ($urandom_range(1)) key = {7'(60 + $urandom_range(3)), 4'd9};
                else                   key = 11'($urandom);
                held_keys.push_back(key);
                send_key(ACT_NOTE_ON, key, 7'($urandom_range(1, 127)));
            end else if (pick < 85 && held_keys.size() != 0) begin
                slot = $urandom_range(held_keys.size() - 1);
                key  = held_keys[slot];
                held_keys.delete(slot);
                if ($urandom_range(3) == 0) send_key(ACT_NOTE_ON, key, 7'd0);
                else send_key(ACT_NOTE_OFF, key, 7'($urandom_range(0, 127)));
            end else begin
                send_key(ACT_NOTE_OFF, 11'($urandom), 7'($urandom));
            end
        end
    endtask

    // Run with neither side idling, so events come every cycle except during sweeps
    task automatic test_steady_stream();
        no_idle = 1'b1;
        random_events(150);
        no_idle = 1'b0;
    endtask

    // Let the output side drain completely before carrying on
    task automatic test_drain_pause();
        random_events(20);
        wait_drained();
        random_events(240);
    endtask

    initial begin
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_NONE;
        m_axis_tready  = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        no_idle        = 1'b0;
        do_reset();
        test_directed();
        test_key_saturation();
        test_wide_chord();
        test_steady_stream();
        test_drain_pause();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_counts.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run, table sweeps included
    initial begin
        #(5_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
rtl/mpt_pkg.sv
rtl/mpt_key_ram.sv
rtl/mpt_update.sv
rtl/midi_polyphony_tracker_core.sv
test/midi_polyphony_tracker_core_tb.sv
